>>> design/srr_pkg.sv
// shared types, constants and codes of the selective repeat receiver
package srr_pkg;

  localparam int SRR_WINDOW_SLOTS = 16;
  localparam int SRR_PAYLOAD_BITS = 32;

  // packet kinds
  localparam logic PKT_DATA = 1'b0;
  localparam logic PKT_END  = 1'b1;

  // result kinds
  localparam logic [1:0] RES_ACK     = 2'd0;
  localparam logic [1:0] RES_DELIVER = 2'd1;
  localparam logic [1:0] RES_DONE    = 2'd2;

  typedef struct packed {
    logic        kind;
    logic        bad_check;
    logic [31:0] seq_no;
    logic [31:0] payload;
  } pkt_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [31:0] out_seq;
    logic [31:0] out_payload;
    logic        last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_RUN_RD,
    ST_RUN_OUT,
    ST_SEND_ACK,
    ST_SEND_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic take;       // input side may transfer
    logic store;      // write new packet into its slot
    logic rd_run;     // read slot at window base
    logic deliver;    // emit window base slot and slide
    logic load_ack;   // emit acknowledge
    logic load_done;  // emit completion notice
  } srr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_end;
    logic is_bad;
    logic in_win;
    logic held_hit;
    logic below;
    logic count_full;
    logic run_held;
    logic out_free;
  } srr_stat_t;

endpackage

>>> design/srr_ram.sv
// generic single write port ram with registered read
module srr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/srr_datapath.sv
// window state, slot storage, classification and result register
module srr_datapath
  import srr_pkg::*;
#(
  parameter int WINDOW_SLOTS = SRR_WINDOW_SLOTS,
  parameter int PAYLOAD_BITS = SRR_PAYLOAD_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      pkt_valid,
  input  pkt_t      pkt,
  input  logic      res_stall,
  output logic      res_valid,
  output res_t      res,
  input  logic      cfg_write,
  input  logic [31:0] cfg_data,
  input  srr_cmd_t  cmd,
  output srr_stat_t stat
);

  localparam int IDXW = $clog2(WINDOW_SLOTS);
  localparam logic [31:0]     WIN32    = 32'(WINDOW_SLOTS);
  localparam logic [IDXW:0]   WINX     = (IDXW+1)'(WINDOW_SLOTS);
  localparam logic [IDXW-1:0] IDX_LAST = IDXW'(WINDOW_SLOTS - 1);
  localparam logic [IDXW-1:0] IDX_ONE  = IDXW'(1);

  logic [31:0]             total_packets;
  logic [31:0]             expected_seq;
  logic [31:0]             received_count;
  logic [IDXW-1:0]         base_ptr;
  logic [WINDOW_SLOTS-1:0] held;
  pkt_t                    item;

  logic [31:0]             offset;
  logic [IDXW:0]           psum;
  logic [IDXW-1:0]         phys;
  logic [63:0]             pay_wide;
  logic [PAYLOAD_BITS-1:0] ram_rdata;
  logic [63:0]             rd_wide;

  // classification of the held item
  always_comb begin
    offset = item.seq_no - expected_seq;
    psum   = {1'b0, base_ptr} + {1'b0, offset[IDXW-1:0]};
    if (psum >= WINX) begin
      psum = psum - WINX;
    end
    phys = psum[IDXW-1:0];
  end

  always_comb begin
    stat.is_end     = (item.kind == PKT_END);
    stat.is_bad     = item.bad_check;
    stat.in_win     = (offset < WIN32);
    stat.held_hit   = held[phys];
    stat.below      = (item.seq_no < expected_seq);
    stat.count_full = (received_count >= total_packets);
    stat.run_held   = held[base_ptr];
    stat.out_free   = !res_valid || !res_stall;
  end

  assign pay_wide = {32'd0, item.payload};
  assign rd_wide  = 64'(ram_rdata);

  srr_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (WINDOW_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (phys),
    .wdata (pay_wide[PAYLOAD_BITS-1:0]),
    .re    (cmd.rd_run),
    .raddr (base_ptr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (pkt_valid && cmd.take) begin
      item <= pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_packets  <= '0;
      expected_seq   <= '0;
      received_count <= '0;
      base_ptr       <= '0;
      held           <= '0;
    end else begin
      if (cfg_write) begin
        total_packets <= cfg_data;
      end
      if (cmd.store) begin
        held[phys]     <= 1'b1;
        received_count <= received_count + 32'd1;
      end
      if (cmd.deliver) begin
        held[base_ptr] <= 1'b0;
        expected_seq   <= expected_seq + 32'd1;
        base_ptr       <= (base_ptr == IDX_LAST) ? '0 : base_ptr + IDX_ONE;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.deliver || cmd.load_ack || cmd.load_done) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      res.out_kind    <= RES_DELIVER;
      res.out_seq     <= expected_seq;
      res.out_payload <= rd_wide[31:0];
      res.last        <= 1'b0;
    end else if (cmd.load_ack) begin
      res.out_kind    <= RES_ACK;
      res.out_seq     <= item.seq_no;
      res.out_payload <= '0;
      res.last        <= 1'b1;
    end else if (cmd.load_done) begin
      res.out_kind    <= RES_DONE;
      res.out_seq     <= '0;
      res.out_payload <= '0;
      res.last        <= 1'b1;
    end
  end

`ifndef SYNTH
  a_one_load: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.deliver, cmd.load_ack, cmd.load_done}))
    else $error("more than one result loaded at once");

  a_deliver_held: assert property (@(posedge clk) disable iff (rst)
    cmd.deliver |-> held[base_ptr])
    else $error("delivery from an empty window base");

  a_store_new: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> (stat.in_win && !held[phys] && !stat.count_full))
    else $error("store of a packet that is not new in window");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    cmd.store |=> (received_count == $past(received_count) + 32'd1))
    else $error("received count did not advance on store");
`endif

endmodule

>>> design/srr_ctrl.sv
// controller state machine of the selective repeat receiver
module srr_ctrl
  import srr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  srr_stat_t stat,
  input  logic      pkt_valid,
  output srr_cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   want_ack;
  logic   want_done;
  logic   want_store;

  // decision for the item under evaluation
  always_comb begin
    want_ack   = 1'b0;
    want_done  = 1'b0;
    want_store = 1'b0;
    if (stat.is_end) begin
      want_done = 1'b1;
    end else if (stat.is_bad) begin
      want_ack = 1'b0;
    end else if (stat.in_win) begin
      if (stat.held_hit) begin
        want_ack = 1'b1;
      end else if (!stat.count_full) begin
        want_store = 1'b1;
      end else begin
        want_done = 1'b1;
      end
    end else if (stat.below) begin
      want_ack = 1'b1;
    end else begin
      want_done = stat.count_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pkt_valid) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (want_store) begin
          state_next = ST_RUN_RD;
        end else if (want_ack) begin
          state_next = stat.out_free ? ST_IDLE : ST_SEND_ACK;
        end else if (want_done) begin
          state_next = stat.out_free ? ST_IDLE : ST_SEND_DONE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_RUN_RD: begin
        if (stat.run_held) begin
          state_next = ST_RUN_OUT;
        end else begin
          state_next = stat.out_free ? ST_IDLE : ST_SEND_ACK;
        end
      end
      ST_RUN_OUT: begin
        if (stat.out_free) state_next = ST_RUN_RD;
      end
      ST_SEND_ACK: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      ST_SEND_DONE: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.take = 1'b1;
      end
      ST_EVAL: begin
        cmd.store     = want_store;
        cmd.load_ack  = want_ack && stat.out_free;
        cmd.load_done = want_done && stat.out_free;
      end
      ST_RUN_RD: begin
        cmd.rd_run   = stat.run_held;
        cmd.load_ack = !stat.run_held && stat.out_free;
      end
      ST_RUN_OUT: begin
        cmd.deliver = stat.out_free;
      end
      ST_SEND_ACK: begin
        cmd.load_ack = stat.out_free;
      end
      ST_SEND_DONE: begin
        cmd.load_done = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

`ifndef SYNTH
  a_run_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN_OUT) |-> ($past(state) == ST_RUN_RD || $past(state) == ST_RUN_OUT))
    else $error("delivery state entered outside a run");

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    (pkt_valid && cmd.take) |=> (state == ST_EVAL))
    else $error("accepted packet not evaluated");

  a_store_eval: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> (state == ST_EVAL))
    else $error("slot store outside evaluation");
`endif

endmodule

>>> design/selective_repeat_receiver.sv
// selective repeat receive window: top level
// Packets enter on the pkt channel and results leave on the res channel, both
// valid/stall, a transfer happening when valid is high and stall is low. The
// one register, total_packets, must be written through cfg_write/cfg_data
// only while the block is idle; the block does not enforce this. A packet
// giving at most one result (end packet, corrupt, duplicate, older, above
// window) is taken, then classified against the window with the result
// register loaded. A new in-window packet is stored in its slot and then
// releases the in-order slots it completes: each delivery reads the slot ram
// at the window base (registered read), then loads the result, and the
// acknowledge is loaded when the run ends. A stall on res makes the block
// wait. The window is a circular buffer of WINDOW_SLOTS ram entries with a
// base pointer, and a held flag per slot in flip-flops cleared by reset; slot
// payloads need no clearing since only held slots are ever read.
module selective_repeat_receiver
  import srr_pkg::*;
#(
  parameter int WINDOW_SLOTS = SRR_WINDOW_SLOTS,
  parameter int PAYLOAD_BITS = SRR_PAYLOAD_BITS
) (
  input  logic        clk,
  input  logic        rst,
  // packet channel
  input  logic        pkt_valid,
  output logic        pkt_stall,
  input  pkt_t        pkt,
  // result channel
  output logic        res_valid,
  input  logic        res_stall,
  output res_t        res,
  // configuration
  input  logic        cfg_write,
  input  logic [31:0] cfg_data
);

  srr_cmd_t  cmd;
  srr_stat_t stat;

  // packets are taken only between items
  assign pkt_stall = !cmd.take;

  srr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .stat      (stat),
    .pkt_valid (pkt_valid),
    .cmd       (cmd)
  );

  srr_datapath #(
    .WINDOW_SLOTS (WINDOW_SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt_valid),
    .pkt       (pkt),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .res       (res),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

`ifndef SYNTH
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (pkt_valid && !pkt_stall) |=> pkt_stall)
    else $error("second packet transfer without evaluation");

  // a stalled result stays put
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res)))
    else $error("stalled result changed or dropped");

  // register writes only while nothing is in flight
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_write |-> (!pkt_stall && !res_valid))
    else $error("configuration write while busy");
`endif

endmodule
